// ----- rtl/core/bmp24_grayscale_stream_assert.svh -----
// Assertion macros for the BMP grayscale stream block.
`ifndef BMP24_GRAYSCALE_STREAM_ASSERT_SVH
`define BMP24_GRAYSCALE_STREAM_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BGS_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BGS_ASSERT_ANY(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BGS_ASSERT(name, clk, rst_n, prop, msg)
`define BGS_ASSERT_ANY(name, clk, prop, msg)
`endif
`endif

// ----- rtl/core/bgs_pkg.sv -----
// Shared types and constants for the BMP grayscale stream block.
`timescale 1ns / 1ps
package bgs_pkg;

	localparam int unsigned HDR_LEN = 54;
	localparam logic [5:0] HDR_LAST = 6'd53;

	localparam logic [5:0] OFS_SIG0 = 6'd0;
	localparam logic [5:0] OFS_SIG1 = 6'd1;
	localparam logic [5:0] OFS_W0 = 6'd18;
	localparam logic [5:0] OFS_W1 = 6'd19;
	localparam logic [5:0] OFS_W2 = 6'd20;
	localparam logic [5:0] OFS_W3 = 6'd21;
	localparam logic [5:0] OFS_H0 = 6'd22;
	localparam logic [5:0] OFS_H1 = 6'd23;
	localparam logic [5:0] OFS_H2 = 6'd24;
	localparam logic [5:0] OFS_H3 = 6'd25;
	localparam logic [5:0] OFS_BPP0 = 6'd28;
	localparam logic [5:0] OFS_BPP1 = 6'd29;

	localparam logic [7:0] SIG_B = 8'h42;
	localparam logic [7:0] SIG_M = 8'h4D;
	localparam logic [7:0] BPP_24 = 8'd24;

	localparam logic [31:0] MAX_WIDTH = 32'd4096;
	localparam logic [31:0] MAX_HEIGHT = 32'd4096;

	// gray = floor((30r + 59g + 11b) / 100), the divide done as (s * 5243) >> 19
	localparam logic [14:0] W_RED = 15'd30;
	localparam logic [14:0] W_GREEN = 15'd59;
	localparam logic [14:0] W_BLUE = 15'd11;
	localparam logic [27:0] GRAY_RECIP = 28'd5243;
	localparam int unsigned GRAY_SHIFT = 19;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW = 2;

	typedef enum logic [1:0] {
		KIND_HDR = 2'd0,
		KIND_PIX = 2'd1,
		KIND_PAD = 2'd2,
		KIND_ERR = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [14:0] sum;
	} cmd_t;

	typedef struct packed {
		logic en;
		logic [5:0] addr;
		logic [7:0] data;
	} hdr_wr_t;

endpackage

// ----- rtl/core/bgs_fifo.sv -----
// Short command queue between the byte parser and the output sequencer.
`timescale 1ns / 1ps
`include "bmp24_grayscale_stream_assert.svh"
module bgs_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bgs_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output bgs_pkg::cmd_t pop_cmd
);

	bgs_pkg::cmd_t mem_q [bgs_pkg::FIFO_DEPTH];
	logic [bgs_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [bgs_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [bgs_pkg::FIFO_AW:0] count_q;

	assign full = (count_q == (bgs_pkg::FIFO_AW+1)'(bgs_pkg::FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`BGS_ASSERT(a_no_overflow, clk, arst_n, push |-> !full, "queue push while full")
	`BGS_ASSERT(a_no_underflow, clk, arst_n, pop |-> !empty, "queue pop while empty")
	`BGS_ASSERT_ANY(a_count_bound, clk, count_q <= (bgs_pkg::FIFO_AW+1)'(bgs_pkg::FIFO_DEPTH), "queue count out of range")

endmodule

// ----- rtl/core/bgs_front.sv -----
// Byte parser: header capture and check, pixel assembly, padding and row tracking.
`timescale 1ns / 1ps
`include "bmp24_grayscale_stream_assert.svh"
module bgs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_start,
	input  logic              q_full,
	output logic              push,
	output bgs_pkg::cmd_t     push_cmd,
	output bgs_pkg::hdr_wr_t  hdr_wr,
	input  logic              hdr_done
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PIXEL,
		PH_PAD,
		PH_IDLE
	} phase_t;

	phase_t phase_q, phase_d, ph;
	logic [5:0] count_q, count_d, cnt;
	logic ok_q, ok_d;
	logic [31:0] w_q, w_d;
	logic [31:0] h_q, h_d;
	logic [12:0] width_q, width_d;
	logic [12:0] rows_q, rows_d, rows_new;
	logic [12:0] col_q, col_d, col_next;
	logic [1:0] bip_q, bip_d;
	logic [1:0] pad_q, pad_d, pad_next;
	logic [7:0] blue_q, blue_d;
	logic [7:0] green_q, green_d;
	logic pend_q, pend_d;
	logic acc;
	logic hdr_good;

	assign in_ready = !pend_q && !q_full;
	assign acc = in_valid && in_ready;

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		ok_d = ok_q;
		w_d = w_q;
		h_d = h_q;
		width_d = width_q;
		rows_d = rows_q;
		col_d = col_q;
		bip_d = bip_q;
		pad_d = pad_q;
		blue_d = blue_q;
		green_d = green_q;
		pend_d = pend_q && !hdr_done;
		push = 1'b0;
		push_cmd = '{kind: bgs_pkg::KIND_HDR, sum: '0};
		hdr_wr = '0;
		ph = in_start ? PH_HEADER : phase_q;
		cnt = in_start ? 6'd0 : count_q;
		hdr_good = 1'b0;
		rows_new = '0;
		col_next = col_q + 13'd1;
		pad_next = pad_q + 2'd1;
		if (acc) begin
			phase_d = ph;
			unique case (ph)
				PH_HEADER: begin
					hdr_wr.en = 1'b1;
					hdr_wr.addr = cnt;
					hdr_wr.data = in_byte;
					count_d = cnt + 6'd1;
					case (cnt)
						bgs_pkg::OFS_SIG0: ok_d = (in_byte == bgs_pkg::SIG_B);
						bgs_pkg::OFS_SIG1: ok_d = ok_q && (in_byte == bgs_pkg::SIG_M);
						bgs_pkg::OFS_BPP0: ok_d = ok_q && (in_byte == bgs_pkg::BPP_24);
						bgs_pkg::OFS_BPP1: ok_d = ok_q && (in_byte == 8'd0);
						bgs_pkg::OFS_W0: w_d[7:0] = in_byte;
						bgs_pkg::OFS_W1: w_d[15:8] = in_byte;
						bgs_pkg::OFS_W2: w_d[23:16] = in_byte;
						bgs_pkg::OFS_W3: w_d[31:24] = in_byte;
						bgs_pkg::OFS_H0: h_d[7:0] = in_byte;
						bgs_pkg::OFS_H1: h_d[15:8] = in_byte;
						bgs_pkg::OFS_H2: h_d[23:16] = in_byte;
						bgs_pkg::OFS_H3: h_d[31:24] = in_byte;
						default: ;
					endcase
					if (cnt == bgs_pkg::HDR_LAST) begin
						hdr_good = ok_q && !w_q[31] && (w_q <= bgs_pkg::MAX_WIDTH);
						push = 1'b1;
						if (hdr_good) begin
							push_cmd.kind = bgs_pkg::KIND_HDR;
							pend_d = 1'b1;
							if (h_q[31] || (h_q == '0)) begin
								rows_new = '0;
							end else if (h_q > bgs_pkg::MAX_HEIGHT) begin
								rows_new = bgs_pkg::MAX_HEIGHT[12:0];
							end else begin
								rows_new = h_q[12:0];
							end
							width_d = w_q[12:0];
							rows_d = rows_new;
							col_d = '0;
							bip_d = '0;
							pad_d = '0;
							phase_d = ((rows_new == '0) || (w_q[12:0] == '0)) ? PH_IDLE : PH_PIXEL;
						end else begin
							push_cmd.kind = bgs_pkg::KIND_ERR;
							phase_d = PH_IDLE;
						end
					end
				end
				PH_PIXEL: begin
					unique case (bip_q)
						2'd0: begin
							blue_d = in_byte;
							bip_d = 2'd1;
						end
						2'd1: begin
							green_d = in_byte;
							bip_d = 2'd2;
						end
						default: begin
							push = 1'b1;
							push_cmd.kind = bgs_pkg::KIND_PIX;
							push_cmd.sum = bgs_pkg::W_RED * {7'd0, in_byte}
								+ bgs_pkg::W_GREEN * {7'd0, green_q}
								+ bgs_pkg::W_BLUE * {7'd0, blue_q};
							bip_d = 2'd0;
							col_d = col_next;
							if (col_next >= width_q) begin
								if (width_q[1:0] != 2'd0) begin
									phase_d = PH_PAD;
									pad_d = '0;
								end else begin
									col_d = '0;
									pad_d = '0;
									rows_d = rows_q - 13'd1;
									phase_d = (rows_q == 13'd1) ? PH_IDLE : PH_PIXEL;
								end
							end
						end
					endcase
				end
				PH_PAD: begin
					push = 1'b1;
					push_cmd.kind = bgs_pkg::KIND_PAD;
					pad_d = pad_next;
					if (pad_next >= width_q[1:0]) begin
						col_d = '0;
						pad_d = '0;
						rows_d = rows_q - 13'd1;
						phase_d = (rows_q == 13'd1) ? PH_IDLE : PH_PIXEL;
					end
				end
				PH_IDLE: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			count_q <= '0;
			ok_q <= 1'b0;
			width_q <= '0;
			rows_q <= '0;
			col_q <= '0;
			bip_q <= '0;
			pad_q <= '0;
			pend_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
			ok_q <= ok_d;
			width_q <= width_d;
			rows_q <= rows_d;
			col_q <= col_d;
			bip_q <= bip_d;
			pad_q <= pad_d;
			pend_q <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		w_q <= w_d;
		h_q <= h_d;
		blue_q <= blue_d;
		green_q <= green_d;
	end

	`BGS_ASSERT(a_done_when_pending, clk, arst_n, hdr_done |-> pend_q, "burst end without pending header")
	`BGS_ASSERT(a_no_write_in_burst, clk, arst_n, hdr_wr.en |-> !pend_q, "header store written during burst")

endmodule

// ----- rtl/core/bgs_back.sv -----
// Output sequencer: header burst from the header store, gray triples, padding and error words.
`timescale 1ns / 1ps
`include "bmp24_grayscale_stream_assert.svh"
module bgs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  bgs_pkg::hdr_wr_t hdr_wr,
	input  logic             q_empty,
	input  bgs_pkg::cmd_t    q_cmd,
	output logic             pop,
	output logic             hdr_done,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output bgs_pkg::kind_t   out_kind,
	output logic             out_last
);

	logic [7:0] hdr_mem [bgs_pkg::HDR_LEN];
	logic [7:0] mem_rd_q;
	logic [5:0] rd_addr;

	logic valid_q;
	bgs_pkg::kind_t kind_q;
	logic [7:0] byte_q;
	logic [1:0] rep_q;
	logic burst_q;
	logic [5:0] idx_q;

	logic fire, last_now, advance, load;
	logic [27:0] prod;

	assign last_now = burst_q ? (idx_q == bgs_pkg::HDR_LAST) : (rep_q == 2'd0);
	assign fire = valid_q && out_ready;
	assign advance = fire && !last_now;
	assign load = !advance && (!valid_q || out_ready) && !q_empty;
	assign pop = load;
	assign hdr_done = fire && burst_q && last_now;
	assign prod = 28'(q_cmd.sum) * bgs_pkg::GRAY_RECIP;

	always_comb begin
		if (advance && burst_q) begin
			rd_addr = idx_q + 6'd1;
		end else if (load) begin
			rd_addr = '0;
		end else begin
			rd_addr = idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_wr.en) begin
			hdr_mem[hdr_wr.addr] <= hdr_wr.data;
		end
		mem_rd_q <= hdr_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			kind_q <= bgs_pkg::KIND_HDR;
			rep_q <= '0;
			burst_q <= 1'b0;
			idx_q <= '0;
		end else if (advance) begin
			if (burst_q) begin
				idx_q <= idx_q + 6'd1;
			end else begin
				rep_q <= rep_q - 2'd1;
			end
		end else if (load) begin
			valid_q <= 1'b1;
			kind_q <= q_cmd.kind;
			rep_q <= (q_cmd.kind == bgs_pkg::KIND_PIX) ? 2'd2 : 2'd0;
			burst_q <= (q_cmd.kind == bgs_pkg::KIND_HDR);
			idx_q <= '0;
		end else if (fire) begin
			valid_q <= 1'b0;
			burst_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= (q_cmd.kind == bgs_pkg::KIND_PIX) ? prod[bgs_pkg::GRAY_SHIFT +: 8] : 8'd0;
		end
	end

	assign out_valid = valid_q;
	assign out_byte = burst_q ? mem_rd_q : byte_q;
	assign out_kind = kind_q;
	assign out_last = last_now;

	`BGS_ASSERT(a_burst_is_header, clk, arst_n, burst_q |-> (valid_q && (kind_q == bgs_pkg::KIND_HDR)), "burst without header word")

endmodule

// ----- rtl/core/bmp24_grayscale_stream.sv -----
// Top level of the 24-bit BMP to grayscale stream converter.
`timescale 1ns / 1ps
// Takes a 24-bit BMP file one byte per word (tuser marks the first byte of a file) and gives the
// converted file one byte per word, with tuser telling header byte, gray byte, padding zero or
// format error, and tlast marking the final word caused by one input byte. Header bytes 0..52
// are taken one per cycle while the command queue has room and give nothing; the 54th byte of a
// valid header starts a 54-word header burst read from the header store (a bad header gives one
// error word instead), and input is held off until the last burst word is taken. After the header
// one input byte is taken per cycle while the 4-entry command queue has room; each red byte
// produces three output words, so with an always-ready sink the output side sets the sustained rate.
module bmp24_grayscale_stream (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tuser,   // [0] file_start
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [1:0] m_tuser,   // [1:0] kind
	output logic       m_tlast
);

	bgs_pkg::cmd_t push_cmd, pop_cmd;
	bgs_pkg::hdr_wr_t hdr_wr;
	bgs_pkg::kind_t out_kind;
	logic push, pop, q_full, q_empty, hdr_done;

	bgs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_start (s_tuser),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd),
		.hdr_wr   (hdr_wr),
		.hdr_done (hdr_done)
	);

	bgs_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.pop_cmd  (pop_cmd)
	);

	bgs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.hdr_wr    (hdr_wr),
		.q_empty   (q_empty),
		.q_cmd     (pop_cmd),
		.pop       (pop),
		.hdr_done  (hdr_done),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_kind  (out_kind),
		.out_last  (m_tlast)
	);

	assign m_tuser = out_kind;

endmodule

// ----- bench/bmp24_grayscale_checker.sv -----
// Checker for the BMP grayscale stream: predicts output words from accepted input words.
`timescale 1ns / 1ps
module bmp24_grayscale_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tuser,   // [0] file_start
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [7:0] out_byte
	input  logic [1:0] m_tuser,   // [1:0] kind
	input  logic       m_tlast,
	output int         errors,
	output int         outstanding,
	output int         compared
);
	import bgs_pkg::*;

	typedef enum logic [1:0] {
		ST_HEADER,
		ST_PIXELS,
		ST_PADDING,
		ST_IGNORE
	} parse_st_t;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       last;
	} out_word_t;

	out_word_t   expected_words[$];
	logic [7:0]  hdr_mem [0:HDR_LEN-1];
	logic [5:0]  hdr_count;
	parse_st_t   st;
	logic [12:0] img_width;
	logic [12:0] rows_left;
	logic [12:0] column;
	logic [1:0]  pix_byte;
	logic [7:0]  blue;
	logic [7:0]  green;
	logic [1:0]  pad_cnt;

	task automatic emit(input logic [7:0] data, input kind_t kind, input logic last);
		expected_words.push_back('{data: data, kind: kind, last: last});
	endtask

	task automatic clear_parse();
		hdr_count = '0;
		st = ST_HEADER;
		img_width = '0;
		rows_left = '0;
		column = '0;
		pix_byte = '0;
		blue = '0;
		green = '0;
		pad_cnt = '0;
	endtask

	task automatic finish_row();
		column = '0;
		pad_cnt = '0;
		rows_left = rows_left - 13'd1;
		st = (rows_left == 13'd0) ? ST_IGNORE : ST_PIXELS;
	endtask

	task automatic convert_byte(input logic [7:0] b, input logic fs);
		logic [31:0] w;
		logic [31:0] h;
		logic [15:0] bpp;
		logic        ok;
		logic [31:0] sum;
		logic [7:0]  gray;
		if (fs)
			clear_parse();
		case (st)
			ST_HEADER: begin
				if (hdr_count > HDR_LAST) begin
					st = ST_IGNORE;
				end else begin
					hdr_mem[hdr_count] = b;
					if (hdr_count == HDR_LAST) begin
						w = {hdr_mem[OFS_W3], hdr_mem[OFS_W2], hdr_mem[OFS_W1], hdr_mem[OFS_W0]};
						h = {hdr_mem[OFS_H3], hdr_mem[OFS_H2], hdr_mem[OFS_H1], hdr_mem[OFS_H0]};
						bpp = {hdr_mem[OFS_BPP1], hdr_mem[OFS_BPP0]};
						ok = hdr_mem[OFS_SIG0] == SIG_B && hdr_mem[OFS_SIG1] == SIG_M &&
							bpp == {8'd0, BPP_24} && !w[31] && w <= MAX_WIDTH;
						if (!ok) begin
							emit(8'd0, KIND_ERR, 1'b1);
							st = ST_IGNORE;
						end else begin
							for (int i = 0; i < HDR_LEN; i++)
								emit(hdr_mem[i], KIND_HDR, i == HDR_LEN - 1);
							img_width = w[12:0];
							if (h[31] || h == 32'd0)
								rows_left = '0;
							else if (h > MAX_HEIGHT)
								rows_left = MAX_HEIGHT[12:0];
							else
								rows_left = h[12:0];
							column = '0;
							pix_byte = '0;
							pad_cnt = '0;
							st = (rows_left == 13'd0 || img_width == 13'd0) ? ST_IGNORE : ST_PIXELS;
						end
					end
					hdr_count = hdr_count + 6'd1;
				end
			end
			ST_PIXELS: begin
				if (pix_byte == 2'd0) begin
					blue = b;
					pix_byte = 2'd1;
				end else if (pix_byte == 2'd1) begin
					green = b;
					pix_byte = 2'd2;
				end else begin
					sum = 32'd30 * b + 32'd59 * green + 32'd11 * blue;
					gray = 8'(sum / 32'd100);
					emit(gray, KIND_PIX, 1'b0);
					emit(gray, KIND_PIX, 1'b0);
					emit(gray, KIND_PIX, 1'b1);
					pix_byte = '0;
					column = column + 13'd1;
					if (column >= img_width) begin
						if (img_width[1:0] != 2'd0) begin
							st = ST_PADDING;
							pad_cnt = '0;
						end else begin
							finish_row();
						end
					end
				end
			end
			ST_PADDING: begin
				emit(8'd0, KIND_PAD, 1'b1);
				pad_cnt = pad_cnt + 2'd1;
				if (pad_cnt >= img_width[1:0])
					finish_row();
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t w;
		if (!arst_n) begin
			clear_parse();
			expected_words.delete();
			errors = 0;
			compared = 0;
			outstanding = 0;
		end else begin
			if (s_tvalid && s_tready)
				convert_byte(s_tdata, s_tuser);
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					$error("output word with nothing expected: out_byte %0d kind %0d last %0d",
						m_tdata, m_tuser, m_tlast);
					errors++;
				end else begin
					w = expected_words.pop_front();
					compared++;
					if (m_tdata !== w.data) begin
						$error("out_byte mismatch: expected %0d, got %0d", w.data, m_tdata);
						errors++;
					end
					if (m_tuser !== w.kind) begin
						$error("kind mismatch: expected %0d, got %0d", w.kind, m_tuser);
						errors++;
					end
					if (m_tlast !== w.last) begin
						$error("last_of_run mismatch: expected %0d, got %0d", w.last, m_tlast);
						errors++;
					end
				end
			end
			outstanding = expected_words.size();
		end
	end
endmodule

// ----- bench/tb.sv -----
// Testbench top for the BMP grayscale stream: file stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb;
	import bgs_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int TAIL_CYCLES = 64;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic       s_tuser = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic       m_tlast;

	int errors;
	int outstanding;
	int compared;
	int send_idle = 11;
	int recv_idle = 85;
	int quiet_cycles = 0;
	int files_sent = 0;
	int bytes_sent = 0;

	logic [7:0] file_image[$];

	always #6 clk = ~clk;

	bmp24_grayscale_stream u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	bmp24_grayscale_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.errors     (errors),
		.outstanding(outstanding),
		.compared   (compared)
	);

	always @(posedge clk)
		m_tready <= (recv_idle == 0) || ($urandom_range(0, 99) >= recv_idle);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
		$display("bmp24_grayscale_stream verification failed");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic fs);
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= fs;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic build_header(input logic [7:0] s0, input logic [7:0] s1, input logic [31:0] w,
			input logic [31:0] h, input logic [15:0] bpp);
		file_image.delete();
		for (int i = 0; i < HDR_LEN; i++)
			file_image.push_back(8'($urandom));
		file_image[OFS_SIG0] = s0;
		file_image[OFS_SIG1] = s1;
		{file_image[OFS_W3], file_image[OFS_W2], file_image[OFS_W1], file_image[OFS_W0]} = w;
		{file_image[OFS_H3], file_image[OFS_H2], file_image[OFS_H1], file_image[OFS_H0]} = h;
		{file_image[OFS_BPP1], file_image[OFS_BPP0]} = bpp;
	endtask

	task automatic add_random(input int n);
		for (int i = 0; i < n; i++)
			file_image.push_back(8'($urandom));
	endtask

	task automatic stream_file(input logic fs);
		for (int i = 0; i < file_image.size(); i++)
			send_byte(file_image[i], (i == 0) ? fs : 1'b0);
		files_sent++;
		bytes_sent += file_image.size();
	endtask

	// sender holds off until the block has delivered everything predicted so far
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		int w;
		int h;
		int rows;
		int len;
		int sel;
		int mode;
		logic [15:0] bad_bpp;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// valid 3x2 file with no file_start, black and white pixels, trailing bytes
		build_header(SIG_B, SIG_M, 32'd3, 32'd2, 16'd24);
		file_image.push_back(8'd0); file_image.push_back(8'd0); file_image.push_back(8'd0);
		file_image.push_back(8'hFF); file_image.push_back(8'hFF); file_image.push_back(8'hFF);
		add_random(3 + 3 + 12 + 2);
		stream_file(1'b0);

		// header cut short by the next file
		build_header(SIG_B, SIG_M, 32'd1, 32'd1, 16'd24);
		file_image = file_image[0:19];
		stream_file(1'b1);

		drain();

		mode = 0;
		while (bytes_sent < 400) begin
			if (mode == 0 && bytes_sent >= 200) begin
				drain();
				send_idle = 85;
				recv_idle = 11;
				mode = 1;
			end else if (mode == 1 && bytes_sent >= 300) begin
				drain();
				send_idle = 0;
				recv_idle = 0;
				mode = 2;
			end
			sel = $urandom_range(0, 9);
			if (sel < 7) begin
				case ($urandom_range(0, 9))
					0: w = 0;
					1: w = $urandom_range(4090, 4096);
					default: w = $urandom_range(1, 7);
				endcase
				case ($urandom_range(0, 9))
					0: h = 0;
					1: h = -$urandom_range(1, 5);
					2: h = $urandom_range(4097, 9000);
					default: h = $urandom_range(1, 3);
				endcase
				build_header(SIG_B, SIG_M, w, h, 16'd24);
				rows = (h <= 0) ? 0 : ((h > 3) ? 3 : h);
				len = rows * (3 * w + (w % 4));
				if (len > 40)
					len = 40;
				if ($urandom_range(0, 5) == 0)
					len = $urandom_range(0, len);
				add_random(len);
				add_random($urandom_range(0, 4));
				stream_file(1'b1);
			end else if (sel < 9) begin
				build_header(SIG_B, SIG_M, $urandom_range(1, 7), $urandom_range(1, 3), 16'd24);
				case ($urandom_range(0, 4))
					0: file_image[OFS_SIG0] = SIG_B ^ 8'($urandom_range(1, 255));
					1: file_image[OFS_SIG1] = SIG_M ^ 8'($urandom_range(1, 255));
					2: begin
						bad_bpp = 16'($urandom);
						if (bad_bpp == 16'd24)
							bad_bpp = 16'd32;
						{file_image[OFS_BPP1], file_image[OFS_BPP0]} = bad_bpp;
					end
					3: {file_image[OFS_W3], file_image[OFS_W2], file_image[OFS_W1],
						file_image[OFS_W0]} = 32'($urandom_range(4097, 32'h7FFF_FFFF));
					default: {file_image[OFS_W3], file_image[OFS_W2], file_image[OFS_W1],
						file_image[OFS_W0]} = 32'h8000_0000 | 32'($urandom);
				endcase
				add_random($urandom_range(0, 6));
				stream_file(1'b1);
			end else begin
				// loose bytes without file_start
				file_image.delete();
				add_random($urandom_range(1, 12));
				stream_file(1'b0);
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (outstanding != 0)
			$error("%0d expected words never came", outstanding);
		$display("sent %0d files (%0d bytes): valid, malformed, clamped, truncated and noise",
			files_sent, bytes_sent);
		$display("%0d output words compared under three flow-control mixes", compared);
		if (errors == 0 && outstanding == 0)
			$display("bmp24_grayscale_stream verification clean");
		else
			$display("bmp24_grayscale_stream verification failed");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/bgs_pkg.sv
rtl/core/bgs_fifo.sv
rtl/core/bgs_front.sv
rtl/core/bgs_back.sv
rtl/core/bmp24_grayscale_stream.sv
bench/bmp24_grayscale_checker.sv
bench/tb.sv
